[src/rtac_pkg.sv]
// Shared constants, types and lookup functions of the RGBA-to-ASCII cell downsampler.
`default_nettype none
package rtac_pkg;
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_COLS   = 512;
	localparam int MAX_ROWS   = 256;
	localparam int COL_AW     = $clog2(MAX_COLS);
	localparam int ACC_W      = 23;   // holds (pos+1)*cells and (cell+1)*size
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 25;
	localparam int MEM_W      = SUM_W + CNT_W;

	// configuration register indexes
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_CELL_COLUMNS = 3'd2;
	localparam logic [2:0] CFG_CELL_ROWS    = 3'd3;

	// x/10000 = (x * RECIP_LUMA) >> RECIP_SH, exact for any weighted sum up to 2550000
	localparam logic [20:0] RECIP_LUMA = 21'd1717987;
	localparam int          RECIP_SH   = 34;

	typedef struct packed {
		logic clr_en;
		logic init_pos;
		logic load_pixel;
		logic wsum_en;
		logic luma_en;    // weighted sum / 10000
		logic scale_en;   // luma * alpha
		logic div_en;     // product / 255
		logic upd_en;
		logic lvl_load;
		logic lvl_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic settings_ok;
		logic emit;
		logic clr_last;
		logic out_free;
	} sts_t;

	// smallest average that reaches ramp level k: ceil(255*k/9)
	function automatic logic [7:0] lvl_thresh(input logic [3:0] k);
		logic [7:0] t;
		case (k)
			4'd1: t = 8'd29;
			4'd2: t = 8'd57;
			4'd3: t = 8'd85;
			4'd4: t = 8'd114;
			4'd5: t = 8'd142;
			4'd6: t = 8'd170;
			4'd7: t = 8'd199;
			4'd8: t = 8'd227;
			4'd9: t = 8'd255;
			default: t = 8'd0;
		endcase
		return t;
	endfunction

	// " .:-=+*#%@"
	function automatic logic [6:0] ramp_code(input logic [3:0] lvl);
		logic [6:0] c;
		case (lvl)
			4'd0: c = 7'd32;
			4'd1: c = 7'd46;
			4'd2: c = 7'd58;
			4'd3: c = 7'd45;
			4'd4: c = 7'd61;
			4'd5: c = 7'd43;
			4'd6: c = 7'd42;
			4'd7: c = 7'd35;
			4'd8: c = 7'd37;
			default: c = 7'd64;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

[src/rtac_if.sv]
// Valid/ready channel interfaces for pixel words and cell words.
`default_nettype none
interface rtac_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface rtac_cell_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic [8:0] cell_col;
	logic [7:0] cell_row;
	logic       last_cell;
	modport source (output valid, char_code, cell_col, cell_row, last_cell, input ready);
	modport sink (input valid, char_code, cell_col, cell_row, last_cell, output ready);
endinterface
`default_nettype wire

[src/rtac_ctrl.sv]
// Controller state machine of the cell downsampler.
`default_nettype none
module rtac_ctrl
	import rtac_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_hit,
	input  wire logic pix_valid,
	output logic      pix_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_WSUM  = 4'd2;
	localparam logic [3:0] ST_DIVL  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_DIV2  = 4'd6;
	localparam logic [3:0] ST_UPD   = 4'd7;
	localparam logic [3:0] ST_LVLL  = 4'd8;
	localparam logic [3:0] ST_LVL   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0] state_q, state_d;
	logic [3:0] cnt_q;
	logic       stepping;

	assign pix_ready = (state_q == ST_IDLE);
	assign stepping  = (state_q == ST_LVL);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en   = 1'b1;
				cmd.init_pos = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.load_pixel = pix_valid;
				if (pix_valid && sts.settings_ok) state_d = ST_WSUM;
			end
			ST_WSUM: begin
				cmd.wsum_en = 1'b1;
				state_d     = ST_DIVL;
			end
			ST_DIVL: begin
				cmd.luma_en = 1'b1;
				state_d     = ST_MUL;
			end
			ST_MUL: begin
				cmd.scale_en = 1'b1;
				state_d      = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_en = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd_en = 1'b1;
				state_d    = sts.emit ? ST_LVLL : ST_IDLE;
			end
			ST_LVLL: begin
				cmd.lvl_load = 1'b1;
				state_d      = ST_LVL;
			end
			ST_LVL: begin
				cmd.lvl_step = 1'b1;
				if (cnt_q == 4'd8) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		// a register write restarts the frame
		if (cfg_hit) begin
			state_d = ST_CLEAR;
			cmd     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (stepping && state_d == state_q) ? cnt_q + 4'd1 : 4'd0;
		end
	end
endmodule
`default_nettype wire

[src/rtac_dp.sv]
// Datapath: config registers, position tracking, luma unit, column memory, level search.
`default_nettype none
module rtac_dp
	import rtac_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [12:0] cfg_data,
	input  wire logic        cfg_hit,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_blue,
	input  wire logic [7:0]  in_alpha,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       out_char,
	output logic [8:0]       out_col,
	output logic [7:0]       out_row,
	output logic             out_last
);
	logic [12:0] width_q, height_q;
	logic [9:0]  cols_q;
	logic [8:0]  rows_q;

	logic [11:0] x_q, y_q;
	logic [8:0]  ccol_q;
	logic [7:0]  crow_q;
	logic [ACC_W-1:0] acc_x_q, acc_cw_q, acc_y_q, acc_rw_q;
	logic [ACC_W-1:0] c_ext, r_ext, w_ext, h_ext;
	logic col_hit, row_hit, x_last, y_last, is_last;

	logic [7:0]  red_q, green_q, blue_q, alpha_q;
	logic [21:0] wsum_q;
	logic [15:0] sprod_q;
	logic [42:0] luma_prod;
	logic [16:0] div255_sum;
	logic [7:0]  quo_q;
	logic [MEM_W-1:0] mem [MAX_COLS];
	logic [MEM_W-1:0] rd_q;
	logic [COL_AW-1:0] clr_addr_q;
	logic [SUM_W-1:0] new_sum, sum_q;
	logic [CNT_W-1:0] new_cnt, cnt_q;
	logic [8:0]  res_col_q;
	logic [7:0]  res_row_q;
	logic        res_last_q;
	logic [3:0]  k_q, lvl_q;
	logic [32:0] prod;
	logic        mem_we;
	logic [COL_AW-1:0] mem_addr;
	logic [MEM_W-1:0]  mem_wd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd384;
			cols_q   <= 10'd80;
			rows_q   <= 9'd24;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				CFG_CELL_COLUMNS: cols_q   <= cfg_data[9:0];
				CFG_CELL_ROWS:    rows_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign sts.settings_ok = (width_q != 13'd0) && (width_q <= 13'(MAX_WIDTH)) &&
		(height_q != 13'd0) && (height_q <= 13'(MAX_HEIGHT)) &&
		(cols_q != 10'd0) && ({3'b0, cols_q} <= 13'(MAX_COLS)) &&
		({3'b0, cols_q} <= width_q) &&
		(rows_q != 9'd0) && ({4'b0, rows_q} <= 13'(MAX_ROWS)) &&
		({4'b0, rows_q} <= height_q);

	// cell boundaries tracked as scaled products: x+1 ends a cell when
	// (x+1)*C <= (cell+1)*W < (x+2)*C
	assign c_ext   = ACC_W'(cols_q);
	assign r_ext   = ACC_W'(rows_q);
	assign w_ext   = ACC_W'(width_q);
	assign h_ext   = ACC_W'(height_q);
	assign col_hit = (acc_x_q <= acc_cw_q) && (acc_cw_q < acc_x_q + c_ext);
	assign row_hit = (acc_y_q <= acc_rw_q) && (acc_rw_q < acc_y_q + r_ext);
	assign x_last  = ({1'b0, x_q} + 13'd1) == width_q;
	assign y_last  = ({1'b0, y_q} + 13'd1) == height_q;
	assign is_last = (({1'b0, ccol_q} + 10'd1) == cols_q) &&
		(({1'b0, crow_q} + 9'd1) == rows_q);
	assign sts.emit = col_hit && row_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			ccol_q   <= '0;
			crow_q   <= '0;
			acc_x_q  <= ACC_W'(80);
			acc_cw_q <= ACC_W'(640);
			acc_y_q  <= ACC_W'(24);
			acc_rw_q <= ACC_W'(384);
		end else if (cmd.init_pos) begin
			x_q      <= '0;
			y_q      <= '0;
			ccol_q   <= '0;
			crow_q   <= '0;
			acc_x_q  <= c_ext;
			acc_cw_q <= w_ext;
			acc_y_q  <= r_ext;
			acc_rw_q <= h_ext;
		end else if (cmd.upd_en) begin
			if (x_last) begin
				x_q      <= '0;
				acc_x_q  <= c_ext;
				ccol_q   <= '0;
				acc_cw_q <= w_ext;
				if (y_last) begin
					y_q      <= '0;
					acc_y_q  <= r_ext;
					crow_q   <= '0;
					acc_rw_q <= h_ext;
				end else begin
					y_q     <= y_q + 12'd1;
					acc_y_q <= acc_y_q + r_ext;
					if (row_hit) begin
						crow_q   <= crow_q + 8'd1;
						acc_rw_q <= acc_rw_q + h_ext;
					end
				end
			end else begin
				x_q     <= x_q + 12'd1;
				acc_x_q <= acc_x_q + c_ext;
				if (col_hit) begin
					ccol_q   <= ccol_q + 9'd1;
					acc_cw_q <= acc_cw_q + w_ext;
				end
			end
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_addr_q <= '0;
		else if (cfg_hit) clr_addr_q <= '0;
		else if (cmd.clr_en) clr_addr_q <= clr_addr_q + COL_AW'(1);
	end
	assign sts.clr_last = (clr_addr_q == COL_AW'(MAX_COLS - 1));

	// luma: weighted sum, reciprocal multiply for /10000, alpha product,
	// then /255 as (p + (p >> 8) + 1) >> 8, exact for p up to 255*256-1
	assign luma_prod  = 43'(wsum_q) * 43'(RECIP_LUMA);
	assign div255_sum = 17'(sprod_q) + 17'(sprod_q[15:8]) + 17'd1;

	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			red_q   <= in_red;
			green_q <= in_green;
			blue_q  <= in_blue;
			alpha_q <= in_alpha;
		end
		if (cmd.wsum_en)
			wsum_q <= 22'(12'd2126 * red_q) + 22'(13'd7152 * green_q) + 22'(10'd722 * blue_q);
		if (cmd.luma_en)
			quo_q <= luma_prod[RECIP_SH +: 8];
		else if (cmd.div_en)
			quo_q <= div255_sum[15:8];
		if (cmd.scale_en)
			sprod_q <= 16'(quo_q) * 16'(alpha_q);
	end

	// column accumulator memory: sum in the upper bits, count in the lower
	assign new_sum  = rd_q[MEM_W-1:CNT_W] + SUM_W'(quo_q);
	assign new_cnt  = rd_q[CNT_W-1:0] + CNT_W'(1);
	assign mem_we   = cmd.clr_en || cmd.upd_en;
	assign mem_addr = cmd.clr_en ? clr_addr_q : ccol_q;
	assign mem_wd   = (cmd.clr_en || sts.emit) ? '0 : {new_sum, new_cnt};

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		if (cmd.load_pixel) rd_q <= mem[ccol_q];
	end

	// finished cell: level = number of thresholds that sum >= T*count passes
	assign prod = 33'(cnt_q) * 33'(lvl_thresh(k_q));

	always_ff @(posedge clk) begin
		if (cmd.upd_en) begin
			sum_q      <= new_sum;
			cnt_q      <= new_cnt;
			res_col_q  <= ccol_q;
			res_row_q  <= crow_q;
			res_last_q <= is_last;
		end
		if (cmd.lvl_load) begin
			k_q   <= 4'd1;
			lvl_q <= 4'd0;
		end else if (cmd.lvl_step) begin
			k_q <= k_q + 4'd1;
			if (cnt_q != '0 && {1'b0, sum_q} >= prod) lvl_q <= lvl_q + 4'd1;
		end
	end

	// output register
	assign sts.out_free = !out_valid || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char <= ramp_code(lvl_q);
			out_col  <= res_col_q;
			out_row  <= res_row_q;
			out_last <= res_last_q;
		end
	end
endmodule
`default_nettype wire

[src/rgba_to_ascii_cell_downsampler_top.sv]
// Top level of the RGBA-to-ASCII cell downsampler.
// Pixel flow: the block takes no new pixel word until the previous one is through the luma
//   steps (weighted sum, /10000, alpha product, /255) and the column update; a pixel that closes
//   a cell also waits for the 9-step serial threshold search and for the output register to free.
// Cell words: the word of a closing pixel enters the output register once the level search ends.
// Reset: async active low to 640x384 and 80x24 cells, then a clearing sweep of the column memory
//   with pix.ready low; each write to a known register index reruns the sweep.
`default_nettype none
module rgba_to_ascii_cell_downsampler_top
	import rtac_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	rtac_pix_if.sink         pix,
	rtac_cell_if.source      ascii,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [12:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic cfg_hit;

	// writes past the last register are dropped and do not restart the frame
	assign cfg_hit = cfg_we && !cfg_idx[2];

	rtac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_hit   (cfg_hit),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath holds the column memory and the output word register
	rtac_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cfg_hit   (cfg_hit),
		.in_red    (pix.red),
		.in_green  (pix.green),
		.in_blue   (pix.blue),
		.in_alpha  (pix.alpha),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (ascii.valid),
		.out_ready (ascii.ready),
		.out_char  (ascii.char_code),
		.out_col   (ascii.cell_col),
		.out_row   (ascii.cell_row),
		.out_last  (ascii.last_cell)
	);
endmodule
`default_nettype wire

[src/rtac_chk.sv]
// Port-level assertion checker for the cell downsampler, bound to the top level.
`default_nettype none
module rtac_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       pix_ready,
	input wire logic       cell_valid,
	input wire logic       cell_ready,
	input wire logic [6:0] char_code,
	input wire logic       cfg_we,
	input wire logic [2:0] cfg_idx
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_ready |=> cell_valid && $stable(char_code))
		else $error("cell word dropped or changed while stalled");

	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && !cfg_idx[2] |=> !pix_ready)
		else $error("pixel taken during clearing sweep");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> char_code == 7'd32 || char_code == 7'd46 || char_code == 7'd58 ||
			char_code == 7'd45 || char_code == 7'd61 || char_code == 7'd43 ||
			char_code == 7'd42 || char_code == 7'd35 || char_code == 7'd37 ||
			char_code == 7'd64)
		else $error("character outside ramp");
endmodule

bind rgba_to_ascii_cell_downsampler_top rtac_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_ready  (pix.ready),
	.cell_valid (ascii.valid),
	.cell_ready (ascii.ready),
	.char_code  (ascii.char_code),
	.cfg_we     (cfg_we),
	.cfg_idx    (cfg_idx)
);
`default_nettype wire

[test/tb_rgba_to_ascii_cell_downsampler_top.sv]
// Testbench for the RGBA-to-ASCII cell downsampler: self-checking against a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_rgba_to_ascii_cell_downsampler_top;
	import rtac_pkg::*;

	// Cell words can still be in flight inside the block after the last expected one lands.
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 20000;  // covers the clearing sweep and the long output hold
	localparam int HOLD_CYCLES   = 1500;

	// " .:-=+*#%@"
	localparam logic [6:0] GLYPH [10] = '{7'd32, 7'd46, 7'd58, 7'd45, 7'd61,
		7'd43, 7'd42, 7'd35, 7'd37, 7'd64};

	typedef struct packed {
		logic [6:0] char_code;
		logic [8:0] cell_col;
		logic [7:0] cell_row;
		logic       last_cell;
	} cell_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = CFG_IMAGE_WIDTH;
	logic [12:0] cfg_data = '0;

	rtac_pix_if  pix_ch();
	rtac_cell_if cell_ch();

	rgba_to_ascii_cell_downsampler_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.ascii    (cell_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow of the block: registers, column accumulators, raster position
	// ---------------------------------------------------------------
	int unsigned img_w, img_h, cells_x, cells_y;
	int unsigned luma_sum [MAX_COLS];
	int unsigned pix_cnt [MAX_COLS];
	int unsigned pos_x, pos_y, cur_cx, cur_cy;

	cell_word_t  cells_due[$];
	int          mismatches = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          rx_hold = 1'b0;

	function automatic int unsigned cell_edge(int unsigned idx, int unsigned size,
			int unsigned cells);
		longint unsigned p;
		p = longint'(idx) * size;
		return int'(p / cells);
	endfunction

	task automatic clear_frame();
		for (int i = 0; i < MAX_COLS; i++) begin
			luma_sum[i] = 0;
			pix_cnt[i] = 0;
		end
		pos_x = 0;
		pos_y = 0;
		cur_cx = 0;
		cur_cy = 0;
	endtask

	function automatic bit frame_setup_ok();
		if (img_w == 0 || img_w > MAX_WIDTH) return 1'b0;
		if (img_h == 0 || img_h > MAX_HEIGHT) return 1'b0;
		if (cells_x == 0 || cells_x > MAX_COLS || cells_x > img_w) return 1'b0;
		if (cells_y == 0 || cells_y > MAX_ROWS || cells_y > img_h) return 1'b0;
		return 1'b1;
	endfunction

	// Accumulate one pixel; queue a cell word when it closes a cell.
	task automatic accumulate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a);
		longint unsigned luma, avg, lvl;
		int unsigned col_edge, row_edge, c;
		cell_word_t w;
		if (!frame_setup_ok())
			return;
		if (pos_x >= img_w || pos_y >= img_h || cur_cx >= cells_x || cur_cy >= cells_y)
			clear_frame();
		col_edge = cell_edge(cur_cx + 1, img_w, cells_x);
		row_edge = cell_edge(cur_cy + 1, img_h, cells_y);
		luma = (64'd2126 * r + 64'd7152 * g + 64'd722 * b) / 10000;
		luma = luma * a / 255;
		c = cur_cx % MAX_COLS;
		luma_sum[c] = luma_sum[c] + int'(luma);
		pix_cnt[c] = (pix_cnt[c] + 1) & 32'h1FF_FFFF;
		if (pos_x + 1 == col_edge) begin
			if (pos_y + 1 == row_edge) begin
				avg = pix_cnt[c] != 0 ? luma_sum[c] / pix_cnt[c] : 0;
				lvl = avg * 9 / 255;
				if (lvl > 9) lvl = 9;
				w.char_code = GLYPH[lvl];
				w.cell_col = cur_cx[8:0];
				w.cell_row = cur_cy[7:0];
				w.last_cell = (cur_cx + 1 == cells_x) && (cur_cy + 1 == cells_y);
				cells_due.push_back(w);
				luma_sum[c] = 0;
				pix_cnt[c] = 0;
			end
			cur_cx++;
		end
		pos_x++;
		if (pos_x >= img_w) begin
			pos_x = 0;
			cur_cx = 0;
			if (pos_y + 1 == row_edge)
				cur_cy++;
			pos_y++;
			if (pos_y >= img_h) begin
				pos_y = 0;
				cur_cy = 0;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Pixel sender: valid stays high between back-to-back words
	// ---------------------------------------------------------------
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red <= r;
		pix_ch.green <= g;
		pix_ch.blue <= b;
		pix_ch.alpha <= a;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		accumulate_pixel(r, g, b, a);
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Drop valid, then wait out every expected cell word and the tail latency.
	task automatic drain();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (cells_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [12:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_IMAGE_WIDTH: img_w = val;
			CFG_IMAGE_HEIGHT: img_h = val;
			CFG_CELL_COLUMNS: cells_x = val & 13'h3FF;
			CFG_CELL_ROWS: cells_y = val & 13'h1FF;
			default: return;  // unknown index: no restart
		endcase
		clear_frame();
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, int unsigned cx, int unsigned cy);
		write_reg(CFG_IMAGE_WIDTH, 13'(w));
		write_reg(CFG_IMAGE_HEIGHT, 13'(h));
		write_reg(CFG_CELL_COLUMNS, 13'(cx));
		write_reg(CFG_CELL_ROWS, 13'(cy));
	endtask

	// ---------------------------------------------------------------
	// Cell word receiver and checker
	// ---------------------------------------------------------------
	always @(negedge clk)
		cell_ch.ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		cell_word_t want;
		if (arst_n && cell_ch.valid && cell_ch.ready) begin
			if (cells_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected cell word: char %0d col %0d row %0d last %0b",
						cell_ch.char_code, cell_ch.cell_col, cell_ch.cell_row,
						cell_ch.last_cell);
			end else begin
				want = cells_due.pop_front();
				if (want.char_code !== cell_ch.char_code || want.cell_col !== cell_ch.cell_col
						|| want.cell_row !== cell_ch.cell_row
						|| want.last_cell !== cell_ch.last_cell) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cell word mismatch: exp char %0d col %0d row %0d last %0b, got char %0d col %0d row %0d last %0b",
							want.char_code, want.cell_col, want.cell_row, want.last_cell,
							cell_ch.char_code, cell_ch.cell_col, cell_ch.cell_row,
							cell_ch.last_cell);
				end
			end
		end
	end

	// Watchdog: cycles with no word moving on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (cell_ch.valid && cell_ch.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[rgba_to_ascii_cell_downsampler_top] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Power-on geometry; corner pixel values, no cell closes this early.
	task automatic test_reset_geometry();
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
		send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
	endtask

	// 4x4 image in 2x2 cells: white, black, transparent white and half-transparent white cells,
	// then a wrap into the next frame.
	task automatic test_small_cells();
		logic [7:0] v;
		set_frame(4, 4, 2, 2);
		for (int i = 0; i < 16; i++) begin
			v = (i % 4 < 2) ? 8'd255 : 8'd0;
			if (i >= 8) send_pixel(8'd255, 8'd255, 8'd255, (i % 4 < 2) ? 8'd0 : 8'd128);
			else send_pixel(v, v, v, 8'd255);
		end
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
	endtask

	// Bad geometry is ignored; unknown index keeps the frame; masked column and row values.
	task automatic test_bad_settings();
		set_frame(3, 3, 4, 1);  // columns wider than image
		repeat (3) send_random_pixel();
		write_reg(CFG_CELL_COLUMNS, 13'd0);
		repeat (2) send_random_pixel();
		set_frame(13'd5000, 2, 1, 1);  // width beyond the maximum
		repeat (2) send_random_pixel();
		write_reg(CFG_IMAGE_WIDTH, 13'd6);
		write_reg(CFG_IMAGE_HEIGHT, 13'd8191);
		repeat (2) send_random_pixel();
		write_reg(CFG_IMAGE_HEIGHT, 13'd2);
		write_reg(CFG_CELL_COLUMNS, 13'h1003);  // upper bits dropped: 3 columns
		write_reg(CFG_CELL_ROWS, 13'h1E01);  // upper bits dropped: 1 row
		repeat (5) send_random_pixel();
		write_reg(3'd5, 13'h1FFF);  // no such register
		repeat (8) send_random_pixel();
	endtask

	// Widest row at the most columns, then the tallest column at the most rows;
	// the first few cells of each.
	task automatic test_extreme_frames();
		set_frame(MAX_WIDTH, 1, MAX_COLS, 1);
		repeat (64) send_random_pixel();
		set_frame(1, MAX_HEIGHT, 1, MAX_ROWS);
		repeat (64) send_random_pixel();
	endtask

	// Random small geometries and pixels; optionally a long output hold.
	task automatic test_random_frames(int n_items, bit with_hold);
		int sent;
		int unsigned w, h;
		sent = 0;
		while (sent < n_items) begin
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 16);
			if ($urandom_range(9) == 0)
				set_frame(w, h, w + 1, $urandom_range(1, h));  // ignored setting
			else
				set_frame(w, h, $urandom_range(1, w), $urandom_range(1, h));
			if (with_hold) begin
				with_hold = 1'b0;
				fork
					begin
						rx_hold = 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						rx_hold = 1'b0;
					end
				join_none
			end
			repeat ($urandom_range(w * h, 3 * w * h + 4)) begin
				if (sent >= n_items) break;
				send_random_pixel();
				sent++;
			end
			// sender waits for the block to empty before going on
			drain();
			repeat ($urandom_range(w * h)) begin
				if (sent >= n_items) break;
				send_random_pixel();
				sent++;
			end
		end
	endtask

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.red = '0;
		pix_ch.green = '0;
		pix_ch.blue = '0;
		pix_ch.alpha = '0;
		cell_ch.ready = 1'b0;
		img_w = 640;
		img_h = 384;
		cells_x = 80;
		cells_y = 24;
		clear_frame();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 7;
		rx_idle_pct = 64;
		test_reset_geometry();
		test_small_cells();
		test_bad_settings();
		test_extreme_frames();
		test_random_frames(310, 1'b1);
		tx_idle_pct = 64;
		rx_idle_pct = 7;
		test_random_frames(310, 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_frames(310, 1'b0);
		drain();

		if (mismatches == 0 && cells_due.size() == 0)
			$display("[rgba_to_ascii_cell_downsampler_top] OK");
		else
			$display("[rgba_to_ascii_cell_downsampler_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
